// ===== hdl/hcld_pkg.sv =====
`default_nettype none

package hcld_pkg;

  // Line geometry
  localparam int unsigned BYTES_PER_LINE  = 40;
  localparam int unsigned PIXELS_PER_BYTE = 7;
  localparam int unsigned LINE_PIXELS     = BYTES_PER_LINE * PIXELS_PER_BYTE;
  localparam int unsigned POS_W           = $clog2(LINE_PIXELS + 1);
  localparam int unsigned BIT_W           = $clog2(PIXELS_PER_BYTE);

  localparam int unsigned COLOR_W  = 32;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [COLOR_W-1:0] COLOR_BLACK = 32'hFF00_0000;
  localparam logic [COLOR_W-1:0] COLOR_WHITE = 32'hFFFF_FFFF;

  // Color modes
  localparam logic [1:0] MODE_FILL     = 2'd0;
  localparam logic [1:0] MODE_ARTIFACT = 2'd1;
  localparam logic [1:0] MODE_MONO     = 2'd2;

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_EVEN_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_EVEN_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_ODD_LOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_ODD_HIGH  = 3'd4;

  typedef struct packed {
    logic [1:0]                  mode;
    logic [3:0][COLOR_W-1:0]     palette; // even_low, even_high, odd_low, odd_high
  } cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic       absent;
  } byte_t;

  typedef enum logic [1:0] {
    PH_PIXEL,
    PH_FLUSH_A,
    PH_FLUSH_B
  } phase_e;

endpackage

`default_nettype wire

// ===== hdl/hcld_cfg.sv =====
`default_nettype none

module hcld_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [hcld_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [hcld_pkg::COLOR_W-1:0]   cfg_data_i,
  output hcld_pkg::cfg_t                     cfg_o
);
  import hcld_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Decode the register index; ignore writes past the map
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_COLOR_MODE:      cfg_d.mode       = cfg_data_i[1:0];
        REG_COLOR_EVEN_LOW:  cfg_d.palette[0] = cfg_data_i;
        REG_COLOR_EVEN_HIGH: cfg_d.palette[1] = cfg_data_i;
        REG_COLOR_ODD_LOW:   cfg_d.palette[2] = cfg_data_i;
        REG_COLOR_ODD_HIGH:  cfg_d.palette[3] = cfg_data_i;
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode    <= MODE_FILL;
      cfg_q.palette <= {4{COLOR_BLACK}};
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/hcld_byte_buf.sv =====
`default_nettype none

module hcld_byte_buf (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire hcld_pkg::byte_t in_byte_i,
  input  wire logic           done_i,
  output logic                byte_valid_o,
  output hcld_pkg::byte_t     byte_o
);
  import hcld_pkg::*;

  logic  valid_q, valid_d;
  byte_t byte_q;

  // Take a new beat when empty or when the held byte finishes this cycle
  assign in_ready_o   = !valid_q || done_i;
  assign byte_valid_o = valid_q;
  assign byte_o       = byte_q;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= in_byte_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/hcld_engine.sv =====
`default_nettype none

module hcld_engine (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire hcld_pkg::cfg_t              cfg_i,
  input  wire logic                        byte_valid_i,
  input  wire hcld_pkg::byte_t             byte_i,
  output logic                             done_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [hcld_pkg::COLOR_W-1:0]     pixel_color_o,
  output logic                             last_of_run_o,
  output logic                             last_of_line_o
);
  import hcld_pkg::*;

  phase_e               phase_q, phase_d;
  logic [BIT_W-1:0]     bit_q, bit_d;
  logic [POS_W-1:0]     pos_q, pos_d;
  logic                 prev_lit_q, prev_lit_d;
  logic [COLOR_W-1:0]   held0_q, held0_d;
  logic [COLOR_W-1:0]   held1_q, held1_d;
  logic [COLOR_W-1:0]   left_q, left_d;

  logic                 out_valid_q, out_valid_d;
  logic [COLOR_W-1:0]   color_q, color_d;
  logic                 run_q, run_d;
  logic                 line_q, line_d;

  logic                 adv;
  logic                 lit;
  logic                 line_end;
  logic [COLOR_W-1:0]   held1_w;
  logic [COLOR_W-1:0]   raw;
  logic [COLOR_W-1:0]   fin;
  logic                 fill_ok;

  // Result slot is free or drains this cycle
  assign adv = !out_valid_q || out_ready_i;

  // Per-pixel datapath
  always_comb begin
    lit      = !byte_i.absent && byte_i.data[bit_q];
    line_end = (pos_q == POS_W'(LINE_PIXELS - 1));
    // Whiten the previous pixel only while a new pixel is being taken
    held1_w  = ((phase_q == PH_PIXEL) && lit && prev_lit_q) ? COLOR_WHITE : held1_q;
    if (!lit) begin
      raw = COLOR_BLACK;
    end else if (prev_lit_q || cfg_i.mode == MODE_MONO) begin
      raw = COLOR_WHITE;
    end else begin
      raw = cfg_i.palette[{pos_q[0], byte_i.data[7]}];
    end
    // Gap fill never applies to the first pixel of a line
    fill_ok = (cfg_i.mode == MODE_FILL) && (held0_q == COLOR_BLACK) && (left_q == held1_w)
              && ((phase_q != PH_PIXEL) || (pos_q >= POS_W'(3)));
    fin = fill_ok ? left_q : held0_q;
  end

  // Sequencer: one pixel per cycle while not stalled, two flush beats at line end
  always_comb begin
    phase_d     = phase_q;
    bit_d       = bit_q;
    pos_d       = pos_q;
    prev_lit_d  = prev_lit_q;
    held0_d     = held0_q;
    held1_d     = held1_q;
    left_d      = left_q;
    out_valid_d = out_valid_q && !out_ready_i;
    color_d     = color_q;
    run_d       = run_q;
    line_d      = line_q;
    done_o      = 1'b0;
    if (adv && byte_valid_i) begin
      case (phase_q)
        PH_PIXEL: begin
          if (pos_q >= POS_W'(2)) begin
            out_valid_d = 1'b1;
            color_d     = fin;
            run_d       = (bit_q == BIT_W'(PIXELS_PER_BYTE - 1)) && !line_end;
            line_d      = 1'b0;
            left_d      = fin;
          end
          held0_d    = held1_w;
          held1_d    = raw;
          prev_lit_d = lit;
          pos_d      = pos_q + POS_W'(1);
          if (bit_q == BIT_W'(PIXELS_PER_BYTE - 1)) begin
            bit_d = '0;
          end else begin
            bit_d = bit_q + BIT_W'(1);
          end
          if (line_end) begin
            phase_d = PH_FLUSH_A;
          end else if (bit_q == BIT_W'(PIXELS_PER_BYTE - 1)) begin
            done_o = 1'b1;
          end
        end
        PH_FLUSH_A: begin
          out_valid_d = 1'b1;
          color_d     = fin;
          run_d       = 1'b0;
          line_d      = 1'b0;
          left_d      = fin;
          phase_d     = PH_FLUSH_B;
        end
        PH_FLUSH_B: begin
          out_valid_d = 1'b1;
          color_d     = held1_q;
          run_d       = 1'b1;
          line_d      = 1'b1;
          // Return line state to its start values
          pos_d       = '0;
          prev_lit_d  = 1'b0;
          held0_d     = COLOR_BLACK;
          held1_d     = COLOR_BLACK;
          left_d      = COLOR_BLACK;
          phase_d     = PH_PIXEL;
          done_o      = 1'b1;
        end
        default: begin
          phase_d = PH_PIXEL;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_PIXEL;
      bit_q       <= '0;
      pos_q       <= '0;
      prev_lit_q  <= 1'b0;
      held0_q     <= COLOR_BLACK;
      held1_q     <= COLOR_BLACK;
      left_q      <= COLOR_BLACK;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      bit_q       <= bit_d;
      pos_q       <= pos_d;
      prev_lit_q  <= prev_lit_d;
      held0_q     <= held0_d;
      held1_q     <= held1_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    color_q <= color_d;
    run_q   <= run_d;
    line_q  <= line_d;
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_color_o  = color_q;
  assign last_of_run_o  = run_q;
  assign last_of_line_o = line_q;

endmodule

`default_nettype wire

// ===== hdl/hires_artifact_color_line_decoder.sv =====
// Artifact-color decoder for high-resolution screen lines. Feed the bytes of
// each line in order (BYTES_PER_LINE bytes per line, set in hcld_pkg); each
// byte gives seven ABGR pixels, bit 0 first, one result beat per cycle
// while bytes arrive and out_ready_i does not stall; the last byte of a
// line also flushes the two pixels held for look-ahead. The engine produces
// one pixel per cycle, when not stalled, into a single result register.
// Output lags input by two pixels: the first byte of a line yields 5 beats,
// middle bytes 7, the last byte 9 with last_of_line on the final one;
// last_of_run marks each byte's final beat. The input register frees up in
// the cycle a byte's last pixel is produced, so the next byte is taken in
// that same cycle and bytes follow with no gap. Configuration writes
// (register index 0 mode, 1..4 palette) take effect at once and are meant
// for idle periods; cfg_ready_o is always high.
`default_nettype none

module hires_artifact_color_line_decoder (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [7:0]                     data_byte_i,
  input  wire logic                           byte_absent_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [hcld_pkg::COLOR_W-1:0]        pixel_color_o,
  output logic                                last_of_run_o,
  output logic                                last_of_line_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [hcld_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [hcld_pkg::COLOR_W-1:0]   cfg_data_i
);
  import hcld_pkg::*;

  cfg_t  cfg;
  byte_t in_byte;
  byte_t cur_byte;
  logic  byte_valid;
  logic  byte_done;

  assign in_byte.data   = data_byte_i;
  assign in_byte.absent = byte_absent_i;

  hcld_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  hcld_byte_buf u_byte_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte),
    .done_i       (byte_done),
    .byte_valid_o (byte_valid),
    .byte_o       (cur_byte)
  );

  hcld_engine u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .byte_valid_i   (byte_valid),
    .byte_i         (cur_byte),
    .done_o         (byte_done),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_color_o  (pixel_color_o),
    .last_of_run_o  (last_of_run_o),
    .last_of_line_o (last_of_line_o)
  );

endmodule

`default_nettype wire

// ===== hdl/hcld_checker.sv =====
`default_nettype none

module hcld_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_ready_o,
  input wire logic                           out_valid_o,
  input wire logic                           out_ready_i,
  input wire logic [hcld_pkg::COLOR_W-1:0]   pixel_color_o,
  input wire logic                           last_of_run_o,
  input wire logic                           last_of_line_o
);
  import hcld_pkg::*;

  logic [1:0] pending_q, pending_d;
  logic       in_beat;
  logic       run_beat;

  assign in_beat  = in_valid_i && in_ready_o;
  assign run_beat = out_valid_o && out_ready_i && last_of_run_o;

  // Track bytes taken but not yet fully delivered
  always_comb begin
    pending_d = pending_q + {1'b0, in_beat} - {1'b0, run_beat};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_color_o)
      && $stable(last_of_run_o) && $stable(last_of_line_o))
    else $error("result beat dropped or changed while stalled");

  a_line_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_of_line_o |-> last_of_run_o)
    else $error("line end beat not marked as end of byte");

  a_run_has_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_beat |-> pending_q != 2'd0)
    else $error("end of byte delivered with no byte outstanding");

  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q != 2'd3)
    else $error("more bytes outstanding than the buffer holds");

endmodule

bind hires_artifact_color_line_decoder hcld_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .pixel_color_o  (pixel_color_o),
  .last_of_run_o  (last_of_run_o),
  .last_of_line_o (last_of_line_o)
);

`default_nettype wire

// ===== bench/hires_artifact_color_line_decoder_test.sv =====
module hires_artifact_color_line_decoder_test;
  import hcld_pkg::*;

  localparam int unsigned HALF_PERIOD   = 10;
  localparam int unsigned RESET_CYCLES  = 10;
  localparam int unsigned LIMIT_CYCLES  = 4_000_000;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned RANDOM_BYTES  = 380;
  localparam int unsigned SETTLE_CYCLES = 30;
  // Mode code 3 has no name in the package; the block treats it like artifact mode
  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               run_end;
    logic               line_end;
  } pixel_beat_t;

  // DUT connections
  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           data_byte = '0;
  logic                 byte_absent = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [COLOR_W-1:0]   pixel_color;
  logic                 last_of_run;
  logic                 last_of_line;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_COLOR_MODE;
  logic [COLOR_W-1:0]   cfg_data = '0;

  // Stimulus and expected pixels
  byte_t       screen_bytes_q[$];
  pixel_beat_t expected_pixels_q[$];
  logic        byte_taken = 1'b0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned hold_asks = 0;
  int unsigned hold_taken = 0;
  bit          send_idle = 1'b1;
  bit          recv_idle = 1'b1;

  // Decoder state mirror
  logic [1:0]         mode_r = MODE_FILL;
  logic [COLOR_W-1:0] shade_r [4] = '{default: COLOR_BLACK};
  int unsigned        line_pos = 0;
  logic               prev_lit = 1'b0;
  logic [COLOR_W-1:0] held_px [2] = '{default: COLOR_BLACK};
  logic [COLOR_W-1:0] left_px = COLOR_BLACK;

  int unsigned fails = 0;
  int unsigned bytes_n = 0;
  int unsigned beats_n = 0;
  int unsigned lines_n = 0;
  int unsigned reg_writes = 0;

  hires_artifact_color_line_decoder u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .data_byte_i    (data_byte),
    .byte_absent_i  (byte_absent),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .pixel_color_o  (pixel_color),
    .last_of_run_o  (last_of_run),
    .last_of_line_o (last_of_line),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  // Resolve a held pixel against its neighbors; gap fill only in fill mode
  function automatic logic [COLOR_W-1:0] settle_pixel(int unsigned idx,
                                                      logic [COLOR_W-1:0] mid,
                                                      logic [COLOR_W-1:0] right);
    logic [COLOR_W-1:0] c;
    c = mid;
    if (mode_r == MODE_FILL && idx >= 1 && c == COLOR_BLACK && left_px == right)
      c = left_px;
    left_px = c;
    return c;
  endfunction

  // Expand one screen byte into the pixels it releases
  task automatic decode_screen_byte(input logic [7:0] d, input logic absent);
    pixel_beat_t beat;
    logic        lit;
    logic [COLOR_W-1:0] c;
    int unsigned x;
    for (int k = 0; k < PIXELS_PER_BYTE; k++) begin
      x = line_pos;
      lit = !absent && d[k];
      if (lit) begin
        if (prev_lit) begin
          c = COLOR_WHITE;
          held_px[1] = COLOR_WHITE;
        end else if (mode_r == MODE_MONO) begin
          c = COLOR_WHITE;
        end else begin
          c = shade_r[{x[0], d[7]}];
        end
        prev_lit = 1'b1;
      end else begin
        c = COLOR_BLACK;
        prev_lit = 1'b0;
      end
      if (x >= 2)
        expected_pixels_q.push_back('{settle_pixel(x - 2, held_px[0], held_px[1]), 1'b0, 1'b0});
      held_px[0] = held_px[1];
      held_px[1] = c;
      line_pos = x + 1;
      // flush both held pixels at line end and start the next line clean
      if (line_pos >= LINE_PIXELS) begin
        expected_pixels_q.push_back('{settle_pixel(x - 1, held_px[0], held_px[1]), 1'b0, 1'b0});
        expected_pixels_q.push_back('{held_px[1], 1'b0, 1'b1});
        line_pos = 0;
        prev_lit = 1'b0;
        held_px[0] = COLOR_BLACK;
        held_px[1] = COLOR_BLACK;
        left_px = COLOR_BLACK;
      end
    end
    beat = expected_pixels_q.pop_back();
    beat.run_end = 1'b1;
    expected_pixels_q.push_back(beat);
  endtask

  // Sample both handshakes, predict on input beats, check output beats
  always @(posedge clk) begin : check_beats
    pixel_beat_t want;
    byte_taken <= in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        decode_screen_byte(data_byte, byte_absent);
        bytes_n++;
      end
      if (out_valid && out_ready) begin
        beats_n++;
        if (last_of_line) lines_n++;
        if (expected_pixels_q.size() == 0) begin
          $error("unexpected pixel beat: pixel_color %h", pixel_color);
          fails++;
        end else begin
          want = expected_pixels_q.pop_front();
          if (pixel_color !== want.color) begin
            $error("pixel_color: expected %h, actual %h", want.color, pixel_color);
            fails++;
          end
          if (last_of_run !== want.run_end) begin
            $error("last_of_run: expected %b, actual %b", want.run_end, last_of_run);
            fails++;
          end
          if (last_of_line !== want.line_end) begin
            $error("last_of_line: expected %b, actual %b", want.line_end, last_of_line);
            fails++;
          end
        end
      end
    end
  end

  // Feed screen bytes; hold each until taken, then maybe idle
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || byte_taken) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (screen_bytes_q.size() != 0) begin
          {data_byte, byte_absent} <= screen_bytes_q.pop_front();
          in_valid <= 1'b1;
          send_gap <= send_idle ? pick_gap() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Accept pixels; stall at random or for a long requested hold
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_taken != hold_asks) begin
        hold_taken <= hold_taken + 1;
        stall_left <= LONG_HOLD;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else if (recv_idle && $urandom_range(0, 99) < 30) begin
        stall_left <= pick_gap();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_COLOR_MODE:      mode_r = val[1:0];
      REG_COLOR_EVEN_LOW:  shade_r[0] = val;
      REG_COLOR_EVEN_HIGH: shade_r[1] = val;
      REG_COLOR_ODD_LOW:   shade_r[2] = val;
      REG_COLOR_ODD_HIGH:  shade_r[3] = val;
      default: ;
    endcase
    reg_writes++;
  endtask

  function automatic logic [COLOR_W-1:0] pick_color(int unsigned kind,
                                                    logic [COLOR_W-1:0] shared);
    case (kind)
      0: return $urandom();
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h0000_0000;
          1: return 32'hFFFF_FFFF;
          2: return COLOR_BLACK;
          default: return COLOR_WHITE;
        endcase
      end
      2: return shared;
      default: return $urandom_range(0, 1) ? shared : $urandom();
    endcase
  endfunction

  // Reprogram mode and a random subset of the palette while idle
  task automatic program_colors(input logic [1:0] mode);
    logic [COLOR_W-1:0] val;
    logic [COLOR_W-1:0] shared;
    int unsigned        kind;
    kind = $urandom_range(0, 3);
    shared = $urandom();
    val = $urandom();
    val[1:0] = mode;
    write_reg(REG_COLOR_MODE, val);
    for (int i = 0; i < 4; i++)
      if ($urandom_range(0, 3) != 0)
        write_reg(CFG_IDX_W'(REG_COLOR_EVEN_LOW + i), pick_color(kind, shared));
    // unmapped index: must leave every register alone
    if ($urandom_range(0, 9) == 0)
      write_reg(CFG_IDX_W'(REG_COLOR_ODD_HIGH + $urandom_range(1, 3)), $urandom());
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_byte(input logic [7:0] d, input logic absent);
    byte_t b;
    b.data = d;
    b.absent = absent;
    screen_bytes_q.push_back(b);
  endtask

  // Random screen byte, biased toward sparse, solid and striped pixel runs
  function automatic byte_t pick_screen_byte();
    byte_t       b;
    int unsigned r;
    b.absent = ($urandom_range(0, 99) < 7);
    b.data = 8'($urandom());
    r = $urandom_range(0, 99);
    if (r < 25)
      b.data[6:0] = b.data[6:0] & 7'($urandom()) & 7'($urandom());
    else if (r < 35)
      b.data[6:0] = 7'h7F;
    else if (r < 43)
      b.data[6:0] = '0;
    else if (r < 58)
      b.data[6:0] = $urandom_range(0, 1) ? 7'h55 : 7'h2A;
    return b;
  endfunction

  // Wait for every byte to be taken and every pixel to come out
  task automatic wait_drained();
    while (screen_bytes_q.size() != 0 || in_valid || expected_pixels_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : run_test
    logic [7:0]  lead[$];
    logic [1:0]  mode;
    int unsigned phase_n;
    int unsigned n;
    int unsigned random_sent;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed opening: distinct palette, gap fill mode
    write_reg(REG_COLOR_MODE, {30'd0, MODE_FILL});
    write_reg(REG_COLOR_EVEN_LOW, 32'hFF20_4060);
    write_reg(REG_COLOR_EVEN_HIGH, 32'hFF80_A0C0);
    write_reg(REG_COLOR_ODD_LOW, 32'hFF11_3355);
    write_reg(REG_COLOR_ODD_HIGH, 32'hFF77_99BB);
    @(negedge clk);
    cfg_valid <= 1'b0;
    lead = '{8'h00, 8'h7F, 8'hFF, 8'h80, 8'h01, 8'h40, 8'h05, 8'h55, 8'hD5, 8'h2A,
             8'hAA, 8'h49, 8'h11, 8'h03, 8'h36, 8'h6C, 8'h41, 8'h08, 8'hC9, 8'h7F};
    foreach (lead[i]) begin
      queue_byte(lead[i], 1'b0);
      if (i == 9) queue_byte(8'hFF, 1'b1);
      if (i == 14) queue_byte(8'h00, 1'b1);
    end

    // Random phases, each with its own setting and idling mix
    phase_n = 1;
    random_sent = 0;
    while (random_sent < RANDOM_BYTES) begin
      wait_drained();
      case (phase_n)
        1: mode = MODE_ARTIFACT;
        2: mode = MODE_MONO;
        3: mode = MODE_SPARE;
        default: mode = 2'($urandom_range(0, 3));
      endcase
      program_colors(mode);
      n = $urandom_range(15, 60);
      case ($urandom_range(0, 3))
        0: begin send_idle = 1'b0; recv_idle = 1'b0; end
        1: begin send_idle = 1'b1; recv_idle = 1'b0; end
        2: begin send_idle = 1'b0; recv_idle = 1'b1; end
        default: begin send_idle = 1'b1; recv_idle = 1'b1; end
      endcase
      // back-pressure phase: sender keeps pushing into a held-off receiver
      if (phase_n == 2) begin
        send_idle = 1'b0;
        n = 60;
        hold_asks++;
      end
      repeat (n) screen_bytes_q.push_back(pick_screen_byte());
      random_sent += n;
      phase_n++;
    end
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d bytes, %0d pixel beats, %0d full lines, %0d register writes,",
             bytes_n, beats_n, lines_n, reg_writes);
    $display("all four mode codes, mid-line setting changes, absent bytes and stalls.");
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(LIMIT_CYCLES * 2 * HALF_PERIOD);
    $display("status: fail");
    $finish;
  end

endmodule

// ===== hires_artifact_color_line_decoder.f =====
hdl/hcld_pkg.sv
hdl/hcld_cfg.sv
hdl/hcld_byte_buf.sv
hdl/hcld_engine.sv
hdl/hires_artifact_color_line_decoder.sv
hdl/hcld_checker.sv
bench/hires_artifact_color_line_decoder_test.sv
